>>> hdl/lprd_pkg.sv
`default_nettype none

package lprd_pkg;

	// Width of every length-prefixed field on the wire.
	localparam int unsigned FieldBytes = 4;
	localparam int unsigned WordW = 32;

	// Maximum message length after reset.
	localparam logic [WordW-1:0] MaxLenReset = 32'd4096;

	// Input function codes.
	localparam logic FuncData  = 1'b0;
	localparam logic FuncReset = 1'b1;

	// Error codes reported on error_code.
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_FRAME_LEN = 3'd1,
		ERR_TRUNC     = 3'd2,
		ERR_COUNT     = 3'd3,
		ERR_STR_LEN   = 3'd4,
		ERR_OVERRUN   = 3'd5,
		ERR_TRAILING  = 3'd6
	} err_t;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_LEN   = 3'd0,
		PH_COUNT = 3'd1,
		PH_SLEN  = 3'd2,
		PH_DATA  = 3'd3,
		PH_ERR   = 3'd4
	} phase_t;

	// One incoming beat.
	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} req_t;

	// One result beat.
	typedef struct packed {
		logic [7:0]       payload_byte;
		logic             payload_valid;
		logic [WordW-1:0] string_index;
		logic             string_end;
		logic             frame_done;
		logic [2:0]       error_code;
	} rsp_t;

endpackage

`default_nettype wire

>>> hdl/length_prefixed_request_deframer.sv
// A request beat passes through the input stage and then the output register, which holds its result beat.
// Throughput: one byte per cycle; the parse step sits between the input stage and the
// output register, and the input stage advances whenever the output register is free.
// Reset (arst_n low): parser state cleared, maximum length set to 4096, both stages empty.
// A connection reset beat clears the parser state but keeps the maximum length.
`default_nettype none

module length_prefixed_request_deframer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire lprd_pkg::req_t req_beat,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output lprd_pkg::rsp_t     rsp_beat,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [31:0]   cfg_data
);

	// Configuration register.
	logic [31:0] max_len_q;

	// Input stage.
	logic           valid_s1;
	lprd_pkg::req_t req_s1;

	// Output register.
	logic           out_valid_q;
	lprd_pkg::rsp_t out_q;

	// Parser state.
	lprd_pkg::phase_t phase_q, phase_d;
	logic [1:0]       fcnt_q, fcnt_d;
	logic [31:0]      shift_q, shift_d;
	logic [31:0]      frame_left_q, frame_left_d;
	logic [31:0]      strings_left_q, strings_left_d;
	logic [31:0]      str_left_q, str_left_d;
	logic [31:0]      cur_str_q, cur_str_d;
	lprd_pkg::err_t   err_q, err_d;

	// Combinational parse results.
	lprd_pkg::rsp_t rsp_d;
	logic           advance;
	logic           field_done;
	logic [31:0]    field_val;
	logic [31:0]    frame_m4;
	logic [31:0]    frame_dec;
	logic [31:0]    str_dec;
	logic [31:0]    strings_dec;
	logic [31:0]    cur_inc;
	logic [31:0]    nx_strings;
	logic           nx_check;
	logic           done_flag;
	logic           send_flag;
	logic           valid_flag;
	logic [31:0]    idx_val;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = out_valid_q;
	assign rsp_beat  = out_q;

	// Field assembly: the last byte lands in the top lane.
	assign field_done  = (fcnt_q == 2'd3);
	assign field_val   = {req_s1.data_byte, shift_q[23:0]};
	assign frame_m4    = frame_left_q - 32'(lprd_pkg::FieldBytes);
	assign frame_dec   = (frame_left_q != 32'd0) ? frame_left_q - 32'd1 : frame_left_q;
	assign str_dec     = (str_left_q != 32'd0) ? str_left_q - 32'd1 : str_left_q;
	assign strings_dec = strings_left_q - 32'd1;
	assign cur_inc     = cur_str_q + 32'd1;

	// Configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lprd_pkg::MaxLenReset;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_beat;
		end
	end

	// Parser next state.
	always_comb begin
		phase_d        = phase_q;
		fcnt_d         = fcnt_q;
		shift_d        = shift_q;
		frame_left_d   = frame_left_q;
		strings_left_d = strings_left_q;
		str_left_d     = str_left_q;
		cur_str_d      = cur_str_q;
		err_d          = err_q;
		valid_flag     = 1'b0;
		send_flag      = 1'b0;
		done_flag      = 1'b0;
		idx_val        = 32'd0;
		nx_check       = 1'b0;
		nx_strings     = strings_left_q;

		if (req_s1.func == lprd_pkg::FuncReset) begin
			phase_d        = lprd_pkg::PH_LEN;
			fcnt_d         = 2'd0;
			shift_d        = 32'd0;
			frame_left_d   = 32'd0;
			strings_left_d = 32'd0;
			str_left_d     = 32'd0;
			cur_str_d      = 32'd0;
			err_d          = lprd_pkg::ERR_NONE;
		end else begin
			case (phase_q)
				lprd_pkg::PH_LEN: begin
					fcnt_d  = fcnt_q + 2'd1;
					shift_d = shift_q | (32'(req_s1.data_byte) << {fcnt_q, 3'b000});
					if (field_done) begin
						shift_d = 32'd0;
						if (field_val > max_len_q) begin
							err_d   = lprd_pkg::ERR_FRAME_LEN;
							phase_d = lprd_pkg::PH_ERR;
						end else if (field_val < 32'(lprd_pkg::FieldBytes)) begin
							err_d   = lprd_pkg::ERR_TRUNC;
							phase_d = lprd_pkg::PH_ERR;
						end else begin
							frame_left_d = field_val;
							cur_str_d    = 32'd0;
							phase_d      = lprd_pkg::PH_COUNT;
						end
					end
				end
				lprd_pkg::PH_COUNT: begin
					fcnt_d  = fcnt_q + 2'd1;
					shift_d = shift_q | (32'(req_s1.data_byte) << {fcnt_q, 3'b000});
					if (field_done) begin
						shift_d      = 32'd0;
						frame_left_d = frame_m4;
						if (field_val > max_len_q) begin
							err_d   = lprd_pkg::ERR_COUNT;
							phase_d = lprd_pkg::PH_ERR;
						end else begin
							strings_left_d = field_val;
							nx_strings     = field_val;
							cur_str_d      = 32'd0;
							nx_check       = 1'b1;
						end
					end
				end
				lprd_pkg::PH_SLEN: begin
					idx_val = cur_str_q;
					fcnt_d  = fcnt_q + 2'd1;
					shift_d = shift_q | (32'(req_s1.data_byte) << {fcnt_q, 3'b000});
					if (field_done) begin
						shift_d      = 32'd0;
						frame_left_d = frame_m4;
						if (field_val > max_len_q) begin
							err_d   = lprd_pkg::ERR_STR_LEN;
							phase_d = lprd_pkg::PH_ERR;
						end else if (field_val > frame_m4) begin
							err_d   = lprd_pkg::ERR_OVERRUN;
							phase_d = lprd_pkg::PH_ERR;
						end else if (field_val == 32'd0) begin
							send_flag      = 1'b1;
							strings_left_d = strings_dec;
							nx_strings     = strings_dec;
							cur_str_d      = cur_inc;
							nx_check       = 1'b1;
						end else begin
							str_left_d = field_val;
							phase_d    = lprd_pkg::PH_DATA;
						end
					end
				end
				lprd_pkg::PH_DATA: begin
					idx_val      = cur_str_q;
					valid_flag   = 1'b1;
					frame_left_d = frame_dec;
					str_left_d   = str_dec;
					if (str_dec == 32'd0) begin
						send_flag      = 1'b1;
						strings_left_d = strings_dec;
						nx_strings     = strings_dec;
						cur_str_d      = cur_inc;
						nx_check       = 1'b1;
					end
				end
				default: begin
					// Error phase: bytes are dropped until a connection reset.
				end
			endcase

			// Decide what follows once no string is in progress.
			if (nx_check) begin
				if (nx_strings == 32'd0) begin
					if (frame_left_d == 32'd0) begin
						phase_d   = lprd_pkg::PH_LEN;
						cur_str_d = 32'd0;
						done_flag = 1'b1;
					end else begin
						err_d   = lprd_pkg::ERR_TRAILING;
						phase_d = lprd_pkg::PH_ERR;
					end
				end else if (frame_left_d < 32'(lprd_pkg::FieldBytes)) begin
					err_d   = lprd_pkg::ERR_TRUNC;
					phase_d = lprd_pkg::PH_ERR;
				end else begin
					phase_d = lprd_pkg::PH_SLEN;
				end
			end
		end
	end

	// Result beat: once an error is pending, only the error code is reported.
	always_comb begin
		rsp_d = '0;
		rsp_d.error_code = err_d;
		if (err_d == lprd_pkg::ERR_NONE) begin
			rsp_d.payload_byte  = valid_flag ? req_s1.data_byte : 8'd0;
			rsp_d.payload_valid = valid_flag;
			rsp_d.string_index  = idx_val;
			rsp_d.string_end    = send_flag;
			rsp_d.frame_done    = done_flag;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= lprd_pkg::PH_LEN;
			fcnt_q         <= 2'd0;
			shift_q        <= 32'd0;
			frame_left_q   <= 32'd0;
			strings_left_q <= 32'd0;
			str_left_q     <= 32'd0;
			cur_str_q      <= 32'd0;
			err_q          <= lprd_pkg::ERR_NONE;
		end else if (advance) begin
			phase_q        <= phase_d;
			fcnt_q         <= fcnt_d;
			shift_q        <= shift_d;
			frame_left_q   <= frame_left_d;
			strings_left_q <= strings_left_d;
			str_left_q     <= str_left_d;
			cur_str_q      <= cur_str_d;
			err_q          <= err_d;
		end
	end

	// Output register: loads a new beat when the previous one has gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= rsp_d;
		end
	end

endmodule

`default_nettype wire

>>> tb/tb_length_prefixed_request_deframer.sv
module tb_length_prefixed_request_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WatchdogLimit = 2000;
	localparam int unsigned SettleCycles  = 8;
	localparam int unsigned ReportLimit   = 10;

	typedef enum logic [1:0] {STIM_BEAT, STIM_DRAIN, STIM_CFG} stim_kind_t;

	typedef struct {
		stim_kind_t     kind;
		lprd_pkg::req_t beat;
		logic [31:0]    word;
	} stim_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_LONG_FRAME,
		FLAW_SHORT_FRAME,
		FLAW_BIG_COUNT,
		FLAW_BIG_STRING,
		FLAW_MID_RESET,
		FLAW_NOISE
	} flaw_t;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	lprd_pkg::req_t req_beat  = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	lprd_pkg::rsp_t rsp_beat;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [31:0]    cfg_data  = '0;

	length_prefixed_request_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_beat  (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_beat  (rsp_beat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the deframer's parser state and limit register.
	logic [31:0]      max_len_model = lprd_pkg::MaxLenReset;
	lprd_pkg::phase_t parse_phase   = lprd_pkg::PH_LEN;
	logic [1:0]       field_pos     = '0;
	logic [31:0]      field_acc     = '0;
	logic [31:0]      frame_left    = '0;
	logic [31:0]      strings_left  = '0;
	logic [31:0]      str_left      = '0;
	logic [31:0]      str_idx       = '0;
	lprd_pkg::err_t   parse_err     = lprd_pkg::ERR_NONE;

	stim_t          stim_q[$];
	lprd_pkg::rsp_t expected_q[$];
	logic [7:0]     frame_raw[$];

	int unsigned n_accepted   = 0;
	int unsigned n_checked    = 0;
	int unsigned idle_cycles  = 0;
	int unsigned n_bad        = 0;
	int unsigned n_resets     = 0;
	int unsigned n_cfg_writes = 0;
	int unsigned n_frames     = 0;
	int unsigned n_payload    = 0;
	int unsigned n_err_beats  = 0;
	int unsigned gap_left     = 0;
	int unsigned stall_left   = 0;
	int unsigned send_calm    = 0;
	int unsigned recv_calm    = 0;
	int unsigned n_planned    = 0;
	logic [31:0] plan_max     = lprd_pkg::MaxLenReset;

	function automatic void clear_parser();
		parse_phase  = lprd_pkg::PH_LEN;
		field_pos    = '0;
		field_acc    = '0;
		frame_left   = '0;
		strings_left = '0;
		str_left     = '0;
		str_idx      = '0;
		parse_err    = lprd_pkg::ERR_NONE;
	endfunction

	function automatic void raise_error(input lprd_pkg::err_t code);
		parse_err   = code;
		parse_phase = lprd_pkg::PH_ERR;
	endfunction

	// Adds one byte to a little-endian field; true once the fourth byte is in.
	function automatic logic gather_byte(input logic [7:0] b);
		field_acc = field_acc | ({24'd0, b} << (8 * field_pos));
		if (field_pos == 2'd3) begin
			field_pos = '0;
			return 1'b1;
		end
		field_pos = field_pos + 2'd1;
		return 1'b0;
	endfunction

	// Chooses what follows once no string is open; true when the frame is complete.
	function automatic logic close_string_run();
		if (strings_left == 0) begin
			if (frame_left == 0) begin
				parse_phase = lprd_pkg::PH_LEN;
				str_idx     = '0;
				return 1'b1;
			end
			raise_error(lprd_pkg::ERR_TRAILING);
			return 1'b0;
		end
		if (frame_left < lprd_pkg::FieldBytes) begin
			raise_error(lprd_pkg::ERR_TRUNC);
			return 1'b0;
		end
		parse_phase = lprd_pkg::PH_SLEN;
		return 1'b0;
	endfunction

	// Works out the result beat of one request beat and advances the shadow state.
	function automatic lprd_pkg::rsp_t deframe_step(input lprd_pkg::req_t beat);
		lprd_pkg::rsp_t r;
		logic [31:0]    word;
		r = '0;
		if (beat.func == lprd_pkg::FuncReset) begin
			clear_parser();
		end else begin
			case (parse_phase)
				lprd_pkg::PH_LEN: begin
					if (gather_byte(beat.data_byte)) begin
						word      = field_acc;
						field_acc = '0;
						if (word > max_len_model) raise_error(lprd_pkg::ERR_FRAME_LEN);
						else if (word < lprd_pkg::FieldBytes) raise_error(lprd_pkg::ERR_TRUNC);
						else begin
							frame_left  = word;
							str_idx     = '0;
							parse_phase = lprd_pkg::PH_COUNT;
						end
					end
				end
				lprd_pkg::PH_COUNT: begin
					if (gather_byte(beat.data_byte)) begin
						word       = field_acc;
						field_acc  = '0;
						frame_left = frame_left - lprd_pkg::FieldBytes;
						if (word > max_len_model) raise_error(lprd_pkg::ERR_COUNT);
						else begin
							strings_left = word;
							str_idx      = '0;
							r.frame_done = close_string_run();
						end
					end
				end
				lprd_pkg::PH_SLEN: begin
					r.string_index = str_idx;
					if (gather_byte(beat.data_byte)) begin
						word       = field_acc;
						field_acc  = '0;
						frame_left = frame_left - lprd_pkg::FieldBytes;
						if (word > max_len_model) raise_error(lprd_pkg::ERR_STR_LEN);
						else if (word > frame_left) raise_error(lprd_pkg::ERR_OVERRUN);
						else if (word == 0) begin
							r.string_end = 1'b1;
							strings_left = strings_left - 1;
							str_idx      = str_idx + 1;
							r.frame_done = close_string_run();
						end else begin
							str_left    = word;
							parse_phase = lprd_pkg::PH_DATA;
						end
					end
				end
				lprd_pkg::PH_DATA: begin
					r.string_index  = str_idx;
					r.payload_byte  = beat.data_byte;
					r.payload_valid = 1'b1;
					if (frame_left != 0) frame_left = frame_left - 1;
					if (str_left != 0) str_left = str_left - 1;
					if (str_left == 0) begin
						r.string_end = 1'b1;
						strings_left = strings_left - 1;
						str_idx      = str_idx + 1;
						r.frame_done = close_string_run();
					end
				end
				default: begin
				end
			endcase
		end
		// A sticky error masks everything but the code itself.
		if (parse_err != lprd_pkg::ERR_NONE) begin
			r            = '0;
			r.error_code = parse_err;
		end
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned draw_idle();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic plan_beat(input logic func, input logic [7:0] b);
		stim_t e;
		e.kind           = STIM_BEAT;
		e.beat.func      = func;
		e.beat.data_byte = b;
		e.word           = '0;
		stim_q.insert(stim_q.size(), e);
		n_planned++;
	endtask

	task automatic plan_word(input logic [31:0] w);
		int unsigned i;
		for (i = 0; i < lprd_pkg::FieldBytes; i++) plan_beat(lprd_pkg::FuncData, w[8*i +: 8]);
	endtask

	task automatic append_word(input logic [31:0] w);
		int unsigned i;
		for (i = 0; i < lprd_pkg::FieldBytes; i++) frame_raw.insert(frame_raw.size(), w[8*i +: 8]);
	endtask

	// The sender holds back until every outstanding result beat has come.
	task automatic plan_pause();
		stim_t e;
		e.kind = STIM_DRAIN;
		e.beat = '0;
		e.word = '0;
		stim_q.insert(stim_q.size(), e);
	endtask

	task automatic plan_setting(input logic [31:0] value);
		stim_t e;
		plan_pause();
		e.kind = STIM_CFG;
		e.beat = '0;
		e.word = value;
		stim_q.insert(stim_q.size(), e);
		plan_max = value;
	endtask

	// One frame, mostly well formed, with random contents and an occasional defect.
	task automatic plan_frame();
		int unsigned lens[$];
		int unsigned cap, frame_len, roll, n_str, span, victim, cut, i, j;
		flaw_t       flaw;
		logic [31:0] len_word, count_word;
		frame_raw.delete();
		cap       = (plan_max < 200) ? plan_max : 200;
		n_str     = $urandom_range(0, 4);
		frame_len = lprd_pkg::FieldBytes;
		for (i = 0; i < n_str; i++) begin
			roll = $urandom_range(0, 99);
			span = (roll < 70) ? $urandom_range(0, 6) :
				(roll < 95) ? $urandom_range(7, 20) : $urandom_range(21, 60);
			if (frame_len + lprd_pkg::FieldBytes + span > cap) break;
			lens.insert(lens.size(), span);
			frame_len += lprd_pkg::FieldBytes + span;
		end

		roll = $urandom_range(0, 99);
		if (roll < 70) flaw = FLAW_NONE;
		else if (roll < 76) flaw = FLAW_LONG_FRAME;
		else if (roll < 82) flaw = FLAW_SHORT_FRAME;
		else if (roll < 86) flaw = FLAW_BIG_COUNT;
		else if (roll < 90) flaw = FLAW_BIG_STRING;
		else if (roll < 95) flaw = FLAW_MID_RESET;
		else flaw = FLAW_NOISE;
		if (flaw == FLAW_BIG_STRING && lens.size() == 0) flaw = FLAW_BIG_COUNT;
		// Nothing can exceed an all-ones limit.
		if (plan_max == '1 && (flaw == FLAW_BIG_COUNT || flaw == FLAW_BIG_STRING))
			flaw = FLAW_NOISE;

		len_word = frame_len;
		if (flaw == FLAW_LONG_FRAME) len_word = frame_len + $urandom_range(1, 6);
		if (flaw == FLAW_SHORT_FRAME) len_word = frame_len - $urandom_range(1, frame_len);
		count_word = (flaw == FLAW_BIG_COUNT) ? plan_max + 1 : lens.size();
		victim     = (lens.size() != 0) ? $urandom_range(0, lens.size() - 1) : 0;

		append_word(len_word);
		append_word(count_word);
		for (i = 0; i < lens.size(); i++) begin
			append_word((flaw == FLAW_BIG_STRING && i == victim) ? plan_max + 1 : lens[i]);
			for (j = 0; j < lens[i]; j++) frame_raw.insert(frame_raw.size(), 8'($urandom));
		end
		if (flaw == FLAW_NOISE) begin
			frame_raw.delete();
			span = $urandom_range(1, 12);
			for (i = 0; i < span; i++) frame_raw.insert(frame_raw.size(), 8'($urandom));
		end

		cut = $urandom_range(0, frame_raw.size() - 1);
		for (i = 0; i < frame_raw.size(); i++) begin
			if (flaw == FLAW_MID_RESET && i == cut)
				plan_beat(lprd_pkg::FuncReset, 8'($urandom));
			plan_beat(lprd_pkg::FuncData, frame_raw[i]);
		end
		// Errors are sticky, so a broken frame is followed by a connection reset.
		if (flaw != FLAW_NONE || frame_len > plan_max || $urandom_range(0, 19) == 0)
			plan_beat(lprd_pkg::FuncReset, 8'($urandom));
		if ($urandom_range(0, 29) == 0) plan_pause();
	endtask

	// Driver: offers pending beats and register writes, and predicts each taken beat.
	always @(posedge clk) begin : drive_side
		logic req_hold, cfg_hold;
		req_hold = req_valid;
		cfg_hold = cfg_valid;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_q.insert(expected_q.size(), deframe_step(req_beat));
				n_accepted <= n_accepted + 1;
				if (req_beat.func == lprd_pkg::FuncReset) n_resets++;
				req_hold = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				max_len_model = cfg_data;
				n_cfg_writes++;
				cfg_hold = 1'b0;
			end
			// Move to the next pending entry once neither channel holds a beat.
			if (!req_hold && !cfg_hold && stim_q.size() != 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end else begin
					case (stim_q[0].kind)
						STIM_BEAT: begin
							req_beat <= stim_q[0].beat;
							req_hold = 1'b1;
							stim_q.delete(0);
							if (send_calm != 0) begin
								send_calm--;
								gap_left = 0;
							end else begin
								gap_left = draw_idle();
								if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(30, 150);
							end
						end
						STIM_DRAIN: begin
							if (!(req_valid && req_ready) && n_accepted == n_checked)
								stim_q.delete(0);
						end
						default: begin
							cfg_data <= stim_q[0].word;
							cfg_hold = 1'b1;
							stim_q.delete(0);
						end
					endcase
				end
			end
		end
		req_valid <= req_hold;
		cfg_valid <= cfg_hold;
	end

	// Monitor: checks each result beat against the oldest prediction and stalls at random.
	always @(posedge clk) begin : watch_side
		lprd_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_q.size() == 0) begin
				n_bad++;
				if (n_bad <= ReportLimit)
					$display("%0t: unexpected beat: byte %02h vld %b idx %0d end %b done %b err %0d",
						$time, rsp_beat.payload_byte, rsp_beat.payload_valid,
						rsp_beat.string_index, rsp_beat.string_end, rsp_beat.frame_done,
						rsp_beat.error_code);
			end else begin
				want = expected_q.pop_front();
				n_checked <= n_checked + 1;
				if (rsp_beat.payload_byte !== want.payload_byte
						|| rsp_beat.payload_valid !== want.payload_valid
						|| rsp_beat.string_index !== want.string_index
						|| rsp_beat.string_end !== want.string_end
						|| rsp_beat.frame_done !== want.frame_done
						|| rsp_beat.error_code !== want.error_code) begin
					n_bad++;
					if (n_bad <= ReportLimit) begin
						$display("%0t: expected byte %02h vld %b idx %0d end %b done %b err %0d",
							$time, want.payload_byte, want.payload_valid, want.string_index,
							want.string_end, want.frame_done, want.error_code);
						$display("%0t: got      byte %02h vld %b idx %0d end %b done %b err %0d",
							$time, rsp_beat.payload_byte, rsp_beat.payload_valid,
							rsp_beat.string_index, rsp_beat.string_end, rsp_beat.frame_done,
							rsp_beat.error_code);
					end
				end
				n_frames  += want.frame_done;
				n_payload += want.payload_valid;
				if (want.error_code != lprd_pkg::ERR_NONE) n_err_beats++;
			end
			if (recv_calm != 0) begin
				recv_calm--;
				stall_left = 0;
			end else begin
				stall_left = draw_idle();
				if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(30, 150);
			end
		end
		if (stall_left != 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Watchdog: counts cycles in which no beat moves on any channel.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// Stimulus plan, reset and end of run.
	initial begin
		// Directed: connection reset, runt frame length, frame over the limit,
		// an empty frame, and a frame with no room left for a string length.
		plan_beat(lprd_pkg::FuncReset, 8'hFF);
		plan_word(32'd3);
		plan_beat(lprd_pkg::FuncReset, 8'h00);
		plan_word(32'hFFFF_FFFF);
		plan_beat(lprd_pkg::FuncReset, 8'h5A);
		plan_word(32'd4);
		plan_word(32'd0);
		plan_word(32'd6);
		plan_word(32'd1);
		plan_beat(lprd_pkg::FuncReset, 8'h00);

		// Random frames under several limits, the extremes among them.
		while (n_planned < 650) plan_frame();
		plan_setting(32'd0);
		while (n_planned < 720) plan_frame();
		plan_setting(32'hFFFF_FFFF);
		while (n_planned < 1050) plan_frame();
		plan_setting(32'd24);
		while (n_planned < 1350) plan_frame();
		plan_setting(lprd_pkg::MaxLenReset);
		while (n_planned < 1750) plan_frame();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while ((stim_q.size() != 0 || req_valid || cfg_valid || n_accepted != n_checked)
				&& idle_cycles < WatchdogLimit)
			@(negedge clk);

		if (idle_cycles >= WatchdogLimit) begin
			$display("Watchdog expired: no beat moved for %0d cycles, %0d results outstanding",
				idle_cycles, expected_q.size());
			$display("Test completed with failures");
		end else begin
			repeat (SettleCycles) @(negedge clk);
			if (expected_q.size() != 0) begin
				n_bad += expected_q.size();
				$display("%0d predicted result beats never arrived", expected_q.size());
			end
			$display("Sent %0d request beats (%0d connection resets), %0d limit writes.",
				n_accepted, n_resets, n_cfg_writes);
			$display("Checked %0d results: %0d frames, %0d payload bytes, %0d error beats.",
				n_checked, n_frames, n_payload, n_err_beats);
			if (n_bad == 0)
				$display("Test completed successfully");
			else
				$display("Test completed with failures");
		end
		$finish;
	end

endmodule
